### sv/abs_pkg.sv
`default_nettype none
package abs_pkg;

	localparam int unsigned MS_W      = 16;
	localparam int unsigned HOUR_W    = 5;
	localparam int unsigned MIN_W     = 6;
	localparam int unsigned LEVEL_W   = 3;
	localparam int unsigned SEC_W     = 10;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_W     = SEC_W;

	localparam int unsigned PULSE_BIT_DEF = 6;
	localparam logic [LEVEL_W-1:0] MAX_PULSES_RST = 3'd6;
	localparam logic [SEC_W-1:0]   TIMEOUT_RST    = 10'd300;

	typedef enum logic [1:0] {
		OP_MS_TICK  = 2'd0,
		OP_SEC_TICK = 2'd1,
		OP_CLK_UPD  = 2'd2,
		OP_BUTTON   = 2'd3
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ALARM_ENABLE    = 3'd0,
		CFG_ALARM_HOUR      = 3'd1,
		CFG_ALARM_MINUTE    = 3'd2,
		CFG_MAX_PULSES      = 3'd3,
		CFG_TIMEOUT_SECONDS = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic [1:0]        operation;
		logic [HOUR_W-1:0] hour;
		logic [MIN_W-1:0]  minute;
	} in_t;

	typedef struct packed {
		logic beeper;
		logic alarming;
	} out_t;

	typedef struct packed {
		logic               alarm_enable;
		logic [HOUR_W-1:0]  alarm_hour;
		logic [MIN_W-1:0]   alarm_minute;
		logic [LEVEL_W-1:0] max_pulses;
		logic [SEC_W-1:0]   timeout_seconds;
	} cfg_t;

	typedef struct packed {
		logic [MS_W-1:0]    ms_in_second;
		logic               active;
		logic [LEVEL_W-1:0] beep_level;
		logic [LEVEL_W-1:0] beeps_done;
		logic               pin_level;
		logic [SEC_W-1:0]   elapsed_seconds;
	} state_t;

endpackage
`default_nettype wire

### sv/abs_step.sv
`default_nettype none
module abs_step #(
	parameter int unsigned PULSE_BIT = abs_pkg::PULSE_BIT_DEF
) (
	input  wire abs_pkg::state_t st,
	input  wire abs_pkg::cfg_t   cfg,
	input  wire abs_pkg::in_t    req,
	output abs_pkg::state_t      nxt,
	output abs_pkg::out_t        res
);
	import abs_pkg::*;

	logic [MS_W-1:0] ms_inc;

	assign ms_inc = st.ms_in_second + MS_W'(1);

	always_comb begin
		nxt = st;
		case (op_t'(req.operation))
			OP_MS_TICK: begin
				nxt.ms_in_second = ms_inc;
				// pulse bit edge drives the pin while beeps remain this second
				if (st.active && (st.beeps_done < st.beep_level) &&
				    (st.ms_in_second[PULSE_BIT] != ms_inc[PULSE_BIT])) begin
					if (ms_inc[PULSE_BIT]) begin
						nxt.pin_level = 1'b1;
					end else begin
						nxt.pin_level  = 1'b0;
						nxt.beeps_done = st.beeps_done + LEVEL_W'(1);
					end
				end
			end
			OP_SEC_TICK: begin
				nxt.ms_in_second = '0;
				if (st.active) begin
					if (st.elapsed_seconds >= cfg.timeout_seconds) begin
						nxt.active    = 1'b0;
						nxt.pin_level = 1'b0;
					end else begin
						nxt.elapsed_seconds = st.elapsed_seconds + SEC_W'(1);
						if (st.beep_level < cfg.max_pulses) begin
							nxt.beep_level = st.beep_level + LEVEL_W'(1);
						end
						nxt.beeps_done = '0;
					end
				end
			end
			OP_CLK_UPD: begin
				if (cfg.alarm_enable && !st.active && (req.hour == cfg.alarm_hour) &&
				    (req.minute == cfg.alarm_minute)) begin
					nxt.active          = 1'b1;
					nxt.beep_level      = '0;
					nxt.beeps_done      = '0;
					nxt.elapsed_seconds = '0;
				end
			end
			OP_BUTTON: begin
				nxt.active    = 1'b0;
				nxt.pin_level = 1'b0;
			end
			default: begin
				nxt = st;
			end
		endcase
	end

	assign res.beeper   = nxt.pin_level;
	assign res.alarming = nxt.active;

endmodule
`default_nettype wire

### sv/alarm_beeper_sequencer.sv
// Results are registered: in the output register, or in the skid entry while it is held.
// Throughput: one request per cycle while in_ready is high; the state update is a single registered pass.
// A two-entry result buffer (output register plus skid) keeps requests flowing
// while a result waits; in_ready drops only when both entries are full.
// Reset (arst_n low, asynchronous): state cleared, registers to defaults
// (max_pulses 6, timeout 300 s), result buffer emptied.
`default_nettype none
module alarm_beeper_sequencer #(
	parameter int unsigned PULSE_BIT = abs_pkg::PULSE_BIT_DEF
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 in_valid,
	output logic                                in_ready,
	input  wire abs_pkg::in_t                   in_data,
	output logic                                out_valid,
	input  wire                                 out_ready,
	output abs_pkg::out_t                       out_data,
	input  wire                                 cfg_we,
	input  wire [abs_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire [abs_pkg::CFG_W-1:0]            cfg_data
);
	import abs_pkg::*;

	cfg_t   cfg_q;
	state_t state_q;
	state_t state_nxt;
	out_t   res;
	out_t   out_q;
	out_t   skid_q;
	logic   out_valid_q;
	logic   skid_valid_q;
	logic   accept;
	logic   out_free;

	abs_step #(
		.PULSE_BIT(PULSE_BIT)
	) u_step (
		.st (state_q),
		.cfg(cfg_q),
		.req(in_data),
		.nxt(state_nxt),
		.res(res)
	);

	assign in_ready  = !skid_valid_q;
	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.alarm_enable    <= 1'b0;
			cfg_q.alarm_hour      <= '0;
			cfg_q.alarm_minute    <= '0;
			cfg_q.max_pulses      <= MAX_PULSES_RST;
			cfg_q.timeout_seconds <= TIMEOUT_RST;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_ALARM_ENABLE:    cfg_q.alarm_enable    <= cfg_data[0];
				CFG_ALARM_HOUR:      cfg_q.alarm_hour      <= cfg_data[HOUR_W-1:0];
				CFG_ALARM_MINUTE:    cfg_q.alarm_minute    <= cfg_data[MIN_W-1:0];
				CFG_MAX_PULSES:      cfg_q.max_pulses      <= cfg_data[LEVEL_W-1:0];
				CFG_TIMEOUT_SECONDS: cfg_q.timeout_seconds <= cfg_data[SEC_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (accept) begin
			state_q <= state_nxt;
		end
	end

	// result buffer: skid drains into the output register first to keep order
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q  <= accept;
			end
		end else if (accept) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (accept) begin
				out_q <= res;
			end
		end else if (accept) begin
			skid_q <= res;
		end
	end

`ifndef SYNTHESIS
	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry held with empty output register");

	a_pin_only_active: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.pin_level |-> state_q.active)
		else $error("beeper pin high while alarm idle");

	a_beeps_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.beeps_done <= state_q.beep_level)
		else $error("beeps done exceeds beep level");

	a_skid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q && !out_ready |=> skid_valid_q && $stable(out_q) && $stable(skid_q))
		else $error("buffered results changed while stalled");

	a_no_state_change_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(state_q))
		else $error("state changed without an accepted request");
`endif

endmodule
`default_nettype wire

### verif/alarm_beeper_sequencer_tb.sv
`default_nettype none
module alarm_beeper_sequencer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import abs_pkg::*;

	localparam int unsigned PULSE_BIT  = PULSE_BIT_DEF;
	localparam int          PHASE_ITEMS = 120;
	localparam int          N_PHASES   = 8;
	localparam int          CYCLE_CAP  = 1000000;
	localparam int          IDLE_PCT   = 8;

	// Tracks the beeper state as the block should see it and holds the
	// pin/alarming values still owed by the block, oldest first.
	class alarm_scoreboard;
		bit                 arm_en;
		bit [HOUR_W-1:0]    arm_hour;
		bit [MIN_W-1:0]     arm_min;
		bit [LEVEL_W-1:0]   top_level;
		bit [SEC_W-1:0]     limit_s;

		bit [MS_W-1:0]      ms_cnt;
		bit                 running;
		bit [LEVEL_W-1:0]   level;
		bit [LEVEL_W-1:0]   beeps;
		bit                 pin;
		bit [SEC_W-1:0]     secs;

		out_t beeper_q[$];
		int errors;
		int checked;
		int alarms_started;
		int beeps_heard;
		int timeouts;
		int button_stops;

		function new();
			arm_en    = 1'b0;
			arm_hour  = '0;
			arm_min   = '0;
			top_level = MAX_PULSES_RST;
			limit_s   = TIMEOUT_RST;
			ms_cnt    = '0;
			running   = 1'b0;
			level     = '0;
			beeps     = '0;
			pin       = 1'b0;
			secs      = '0;
		endfunction

		function void write_reg(cfg_idx_t idx, logic [CFG_W-1:0] v);
			case (idx)
				CFG_ALARM_ENABLE:    arm_en    = v[0];
				CFG_ALARM_HOUR:      arm_hour  = v[HOUR_W-1:0];
				CFG_ALARM_MINUTE:    arm_min   = v[MIN_W-1:0];
				CFG_MAX_PULSES:      top_level = v[LEVEL_W-1:0];
				CFG_TIMEOUT_SECONDS: limit_s   = v[SEC_W-1:0];
				default: ;
			endcase
		endfunction

		function void note_request(in_t r);
			bit [MS_W-1:0] nxt;
			out_t o;
			case (op_t'(r.operation))
				OP_MS_TICK: begin
					nxt = ms_cnt + MS_W'(1);
					if (running && beeps < level && nxt[PULSE_BIT] != ms_cnt[PULSE_BIT]) begin
						if (nxt[PULSE_BIT]) begin
							pin = 1'b1;
						end else begin
							pin = 1'b0;
							beeps = beeps + LEVEL_W'(1);
							beeps_heard++;
						end
					end
					ms_cnt = nxt;
				end
				OP_SEC_TICK: begin
					ms_cnt = '0;
					if (running) begin
						if (secs >= limit_s) begin
							running = 1'b0;
							pin = 1'b0;
							timeouts++;
						end else begin
							secs = secs + SEC_W'(1);
							if (level < top_level)
								level = level + LEVEL_W'(1);
							beeps = '0;
						end
					end
				end
				OP_CLK_UPD: begin
					if (arm_en && !running && r.hour == arm_hour && r.minute == arm_min) begin
						running = 1'b1;
						level = '0;
						beeps = '0;
						secs = '0;
						alarms_started++;
					end
				end
				default: begin
					if (running)
						button_stops++;
					running = 1'b0;
					pin = 1'b0;
				end
			endcase
			o.beeper   = pin;
			o.alarming = running;
			beeper_q.push_back(o);
		endfunction

		function void check_result(out_t got);
			out_t want;
			if (beeper_q.size() == 0) begin
				errors++;
				$display("%0t: result with nothing pending: beeper=%0b alarming=%0b",
					$time, got.beeper, got.alarming);
				return;
			end
			want = beeper_q.pop_front();
			checked++;
			if (got.beeper !== want.beeper) begin
				errors++;
				$display("%0t: beeper expected %0b actual %0b",
					$time, want.beeper, got.beeper);
			end
			if (got.alarming !== want.alarming) begin
				errors++;
				$display("%0t: alarming expected %0b actual %0b",
					$time, want.alarming, got.alarming);
			end
		endfunction

		function int pending();
			return beeper_q.size();
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n;
	logic             in_valid;
	logic             in_ready;
	in_t              in_data;
	logic             out_valid;
	logic             out_ready = 1'b0;
	out_t             out_data;
	logic             cfg_we;
	cfg_idx_t         cfg_index;
	logic [CFG_W-1:0] cfg_data;

	alarm_scoreboard sb = new();
	cfg_t cur_cfg;
	bit   calm;
	int   sent;
	int   cycles;

	alarm_beeper_sequencer #(.PULSE_BIT(PULSE_BIT)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #6 clk = ~clk;

	always @(negedge clk) begin
		out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(out_data);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_CAP) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Drive one request; returns at the falling edge after acceptance with
	// valid still high, so the next call can keep it high.
	task automatic issue(input op_t op, input logic [HOUR_W-1:0] h, input logic [MIN_W-1:0] m);
		in_t r;
		r.operation = op;
		r.hour      = h;
		r.minute    = m;
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= r;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_request(r);
		sent++;
		@(negedge clk);
	endtask

	task automatic ms_burst(input int n);
		for (int i = 0; i < n; i++)
			issue(OP_MS_TICK, HOUR_W'($urandom_range(31)), MIN_W'($urandom_range(63)));
	endtask

	task automatic wait_drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		@(negedge clk);
	endtask

	task automatic program_regs(input cfg_t c);
		cfg_idx_t         idx [5];
		logic [CFG_W-1:0] val [5];
		idx = '{CFG_ALARM_ENABLE, CFG_ALARM_HOUR, CFG_ALARM_MINUTE, CFG_MAX_PULSES,
			CFG_TIMEOUT_SECONDS};
		val = '{CFG_W'(c.alarm_enable), CFG_W'(c.alarm_hour), CFG_W'(c.alarm_minute),
			CFG_W'(c.max_pulses), CFG_W'(c.timeout_seconds)};
		for (int i = 0; i < 5; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= val[i];
			sb.write_reg(idx[i], val[i]);
			@(negedge clk);
		end
		cfg_we <= 1'b0;
		cur_cfg = c;
	endtask

	initial begin
		cfg_t c;
		int   nsec;
		int   pick;
		int   phase_base;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_data   = '0;
		cfg_we    = 1'b0;
		cfg_index = CFG_ALARM_ENABLE;
		cfg_data  = '0;
		calm      = 1'b0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// defaults: alarm disarmed, so nothing starts
		issue(OP_CLK_UPD, '0, '0);
		issue(OP_MS_TICK, '1, '1);
		issue(OP_SEC_TICK, '0, '0);
		issue(OP_BUTTON, '1, '0);
		issue(OP_CLK_UPD, '1, '1);
		wait_drain();

		// alarm time outside the clock range still matches bit for bit
		c = '{alarm_enable: 1'b1, alarm_hour: 5'd31, alarm_minute: 6'd63,
			max_pulses: 3'd7, timeout_seconds: 10'd2};
		program_regs(c);
		issue(OP_CLK_UPD, 5'd31, 6'd62);
		issue(OP_CLK_UPD, 5'd30, 6'd63);
		issue(OP_CLK_UPD, 5'd31, 6'd63);
		issue(OP_CLK_UPD, 5'd31, 6'd63);
		issue(OP_SEC_TICK, '0, '0);
		ms_burst(130);
		issue(OP_SEC_TICK, '0, '0);
		ms_burst(70);
		issue(OP_SEC_TICK, '0, '0);
		issue(OP_CLK_UPD, 5'd31, 6'd63);
		issue(OP_SEC_TICK, '0, '0);
		ms_burst(70);
		// pin high across the second boundary, cleared by the next falling edge
		issue(OP_SEC_TICK, '0, '0);
		ms_burst(140);
		issue(OP_BUTTON, '0, '0);
		issue(OP_BUTTON, '0, '0);
		wait_drain();

		// zero level cap and zero timeout
		c = '{alarm_enable: 1'b1, alarm_hour: 5'd0, alarm_minute: 6'd0,
			max_pulses: 3'd0, timeout_seconds: 10'd0};
		program_regs(c);
		issue(OP_CLK_UPD, '0, '0);
		ms_burst(200);
		issue(OP_SEC_TICK, '0, '0);
		wait_drain();
		c.alarm_enable = 1'b0;
		program_regs(c);
		issue(OP_CLK_UPD, '0, '0);

		for (int ph = 0; ph < N_PHASES; ph++) begin
			wait_drain();
			c.alarm_enable    = ($urandom_range(9) != 0);
			c.alarm_hour      = ($urandom_range(3) == 0) ? HOUR_W'($urandom_range(31))
				: HOUR_W'($urandom_range(23));
			c.alarm_minute    = ($urandom_range(3) == 0) ? MIN_W'($urandom_range(63))
				: MIN_W'($urandom_range(59));
			c.max_pulses      = LEVEL_W'($urandom_range(7));
			c.timeout_seconds = ($urandom_range(7) == 0) ? SEC_W'($urandom_range(1023))
				: SEC_W'($urandom_range(6));
			case (ph)
				0: begin
					c.alarm_enable    = 1'b1;
					c.max_pulses      = 3'd7;
					c.timeout_seconds = 10'd1023;
				end
				1: begin
					c.alarm_enable    = 1'b1;
					c.max_pulses      = 3'd1;
					c.timeout_seconds = 10'd1;
				end
				2: begin
					c.max_pulses      = 3'd0;
					c.timeout_seconds = 10'd3;
				end
				default: ;
			endcase
			program_regs(c);
			calm = (ph == 3);
			phase_base = sent;
			while (sent - phase_base < PHASE_ITEMS) begin
				pick = $urandom_range(99);
				if (pick < 75) begin
					// alarm episode: arm, run some seconds of beeping, maybe stop it
					if ($urandom_range(9) < 8)
						issue(OP_CLK_UPD, cur_cfg.alarm_hour, cur_cfg.alarm_minute);
					else if ($urandom_range(1))
						issue(OP_CLK_UPD, cur_cfg.alarm_hour ^ HOUR_W'(1 << $urandom_range(4)),
							cur_cfg.alarm_minute);
					else
						issue(OP_CLK_UPD, cur_cfg.alarm_hour,
							cur_cfg.alarm_minute ^ MIN_W'(1 << $urandom_range(5)));
					nsec = $urandom_range(6);
					for (int s = 0; s < nsec && sent - phase_base < PHASE_ITEMS; s++) begin
						pick = $urandom_range(99);
						if (pick < 70)
							ms_burst($urandom_range(160));
						else if (pick < 95)
							ms_burst($urandom_range(450, 160));
						else
							ms_burst($urandom_range(1000, 450));
						if ($urandom_range(9) == 0) begin
							issue(op_t'($urandom_range(3)), HOUR_W'($urandom_range(31)),
								MIN_W'($urandom_range(63)));
						end
						issue(OP_SEC_TICK, HOUR_W'($urandom_range(31)), MIN_W'($urandom_range(63)));
					end
					if ($urandom_range(1)) begin
						issue(OP_BUTTON, HOUR_W'($urandom_range(31)), MIN_W'($urandom_range(63)));
					end
				end else if (pick < 95) begin
					nsec = $urandom_range(10, 1);
					for (int k = 0; k < nsec; k++) begin
						issue(op_t'($urandom_range(3)), HOUR_W'($urandom_range(31)),
							MIN_W'($urandom_range(63)));
					end
				end else begin
					// sender holds off until the block has caught up
					wait_drain();
				end
			end
		end
		calm = 1'b0;
		wait_drain();
		repeat (4) @(posedge clk);

		$display("Covered %0d requests, %0d results checked, %0d alarms started, %0d beeps.",
			sent, sb.checked, sb.alarms_started, sb.beeps_heard);
		$display("Alarms ended by timeout: %0d, by button: %0d.", sb.timeouts, sb.button_stops);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
`default_nettype wire
